FILE: rtl/core/hcli_pkg.sv
package hcli_pkg;

  localparam int SAMP_W    = 24;
  localparam int ADDR_W    = 32;
  localparam int PEAK_W    = 23;
  localparam int LEN_W     = 7;
  localparam int THR_W     = 23;
  localparam int OV_W      = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 23;

  localparam int ACC_W = 64;
  localparam int DEN_W = 21;
  localparam int QUO_W = 27;
  localparam int QBITS = 24;

  localparam logic [LEN_W-1:0] MAX_CLIP_LEN = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_OVERSHOOT = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 23'd1048576;
  localparam logic [OV_W-1:0]  OV_RESET  = 16'd6144;

endpackage

FILE: rtl/core/hermite_clip_interpolator.sv
// channel   dir  handshake              payload
// config    in   cfg_we_i               cfg_idx_i, cfg_data_i
// region    in   in_valid_i/in_stall_o  anchors, counts, clip_length_i, start_address_i, polarity_i
// sample    out  out_valid_o/out_stall_i sample_o, sample_address_o, peak_estimate_o, last_o
//
// one region at a time: setup, then per sample a line or hermite pass on the
// shared multiplier, the bit-serial divider and an output step that holds
// while out_stall_i is high
// in_stall_o is high from acceptance until the last sample is taken or zero-length setup ends
// reset loads the register defaults and clears the sequencer
module hermite_clip_interpolator import hcli_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SAMP_W-1:0] before_far_i,
  input  logic signed [SAMP_W-1:0] before_mid_i,
  input  logic signed [SAMP_W-1:0] before_last_i,
  input  logic [1:0]               before_count_i,
  input  logic signed [SAMP_W-1:0] after_first_i,
  input  logic signed [SAMP_W-1:0] after_second_i,
  input  logic signed [SAMP_W-1:0] after_third_i,
  input  logic [1:0]               after_count_i,
  input  logic [LEN_W-1:0]         clip_length_i,
  input  logic [ADDR_W-1:0]        start_address_i,
  input  logic                     polarity_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SAMP_W-1:0] sample_o,
  output logic [ADDR_W-1:0]        sample_address_o,
  output logic [PEAK_W-1:0]        peak_estimate_o,
  output logic                     last_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_SAMP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  logic [THR_W-1:0] thr_q;
  logic [OV_W-1:0]  ov_q;

  logic signed [SAMP_W-1:0] p0_q, p1_q;
  logic signed [26:0]       m0x2_q, m1x2_q;
  logic [25:0]              ssum_q;
  logic [LEN_W-1:0]         len_q, n_q, k_q;
  logic                     lin_q, neg_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [12:0]              n2_q, k2_q;
  logic [18:0]              n3_q, k3_q, k2n_q, kn2_q;
  logic [26:0]              cap_q;
  logic [PEAK_W-1:0]        peak_q;
  logic signed [34:0]       m0n_q, m1n_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [59:0]       prod_q;
  logic signed [SAMP_W-1:0] samp_q;
  logic                     ovld_q, last_q;

  logic signed [35:0]       mul_a;
  logic signed [23:0]       mul_b;

  // capture path
  logic                     accept;
  logic [LEN_W-1:0]         len_in;
  logic signed [24:0]       db_in, da_in;
  logic [24:0]              ab_in, aa_in;
  logic signed [26:0]       m0_in, m1_in;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign len_in = (clip_length_i > MAX_CLIP_LEN) ? MAX_CLIP_LEN : clip_length_i;
  assign db_in  = {before_last_i[23], before_last_i} - {before_mid_i[23], before_mid_i};
  assign da_in  = {after_second_i[23], after_second_i} - {after_first_i[23], after_first_i};
  assign ab_in  = (before_count_i < 2'd2) ? '0 :
                  (db_in[24] ? 25'(-db_in) : 25'(db_in));
  assign aa_in  = (after_count_i < 2'd2) ? '0 :
                  (da_in[24] ? 25'(-da_in) : 25'(da_in));
  assign m0_in  = (before_count_i == 2'd3) ?
                  ({{3{before_last_i[23]}}, before_last_i} - {{3{before_far_i[23]}}, before_far_i}) :
                  {db_in[24], db_in, 1'b0};
  assign m1_in  = (after_count_i == 2'd3) ?
                  ({{3{after_third_i[23]}}, after_third_i} - {{3{after_first_i[23]}}, after_first_i}) :
                  {da_in[24], da_in, 1'b0};

  // hermite basis numerators over n^3
  logic signed [21:0] h00, h10, h01, h11;
  logic signed [21:0] k3s, k2ns, kn2s, n3s;
  assign k3s  = $signed({3'b000, k3_q});
  assign k2ns = $signed({3'b000, k2n_q});
  assign kn2s = $signed({3'b000, kn2_q});
  assign n3s  = $signed({3'b000, n3_q});
  assign h00  = (k3s <<< 1) - (k2ns + (k2ns <<< 1)) + n3s;
  assign h10  = k3s - (k2ns <<< 1) + kn2s;
  assign h01  = (k2ns + (k2ns <<< 1)) - (k3s <<< 1);
  assign h11  = k3s - k2ns;

  logic signed [24:0] dp;
  assign dp = {p1_q[23], p1_q} - {p0_q[23], p0_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SETUP) begin
      case (cnt_q)
        4'd0: begin mul_a = {29'd0, n_q}; mul_b = {17'd0, n_q}; end
        4'd1: begin mul_a = {23'd0, prod_q[12:0]}; mul_b = {17'd0, n_q}; end
        4'd2: begin mul_a = {13'd0, thr_q}; mul_b = {8'd0, ov_q}; end
        4'd3: begin mul_a = {10'd0, ssum_q}; mul_b = {17'd0, len_q}; end
        4'd4: begin mul_a = {{9{m0x2_q[26]}}, m0x2_q}; mul_b = {17'd0, n_q}; end
        4'd5: begin mul_a = {{9{m1x2_q[26]}}, m1x2_q}; mul_b = {17'd0, n_q}; end
        default: ;
      endcase
    end else if (state_q == ST_SAMP && lin_q) begin
      case (cnt_q)
        4'd0: begin mul_a = {{12{p0_q[23]}}, p0_q}; mul_b = {17'd0, n_q}; end
        4'd1: begin mul_a = {{11{dp[24]}}, dp}; mul_b = {17'd0, k_q}; end
        default: ;
      endcase
    end else if (state_q == ST_SAMP) begin
      case (cnt_q)
        4'd0: begin mul_a = {29'd0, k_q}; mul_b = {17'd0, k_q}; end
        4'd1: begin mul_a = {23'd0, prod_q[12:0]}; mul_b = {17'd0, k_q}; end
        4'd2: begin mul_a = {23'd0, k2_q}; mul_b = {17'd0, n_q}; end
        4'd3: begin mul_a = {29'd0, k_q}; mul_b = {11'd0, n2_q}; end
        4'd4: begin mul_a = {{12{p0_q[23]}}, p0_q}; mul_b = {{2{h00[21]}}, h00}; end
        4'd5: begin mul_a = {m0n_q[34], m0n_q}; mul_b = {{2{h10[21]}}, h10}; end
        4'd6: begin mul_a = {{12{p1_q[23]}}, p1_q}; mul_b = {{2{h01[21]}}, h01}; end
        4'd7: begin mul_a = {m1n_q[34], m1n_q}; mul_b = {{2{h11[21]}}, h11}; end
        default: ;
      endcase
    end
  end

  // peak from the registered products
  logic [29:0] raw;
  logic [29:0] pk_min;
  assign raw    = 30'(thr_q) + 30'(prod_q[31:3]);
  assign pk_min = (raw < 30'(cap_q)) ? raw : 30'(cap_q);

  // divider hookup
  logic signed [ACC_W-1:0] prod_ext, sum_last, div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_start, div_done;
  logic signed [QUO_W-1:0] div_quo;

  assign prod_ext  = {{4{prod_q[59]}}, prod_q};
  assign sum_last  = acc_q + prod_ext;
  assign div_start = (state_q == ST_SAMP) &&
                     ((lin_q && cnt_q == 4'd2) || (!lin_q && cnt_q == 4'd8));
  assign div_num   = lin_q ? ((sum_last <<< 1) + ACC_W'(n_q))
                           : ((sum_last <<< 1) + ACC_W'({n3_q, 1'b0}));
  assign div_den   = lin_q ? DEN_W'({n_q, 1'b0}) : DEN_W'({n3_q, 2'b00});

  hcli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // clamp against the peak (hermite only), then saturate
  logic signed [QUO_W-1:0] pk_s, v_cl;
  logic signed [SAMP_W-1:0] v_sat;
  assign pk_s = $signed({4'b0000, peak_q});
  always_comb begin
    v_cl = div_quo;
    if (!lin_q) begin
      if (!neg_q && div_quo > pk_s) v_cl = pk_s;
      if (neg_q && div_quo < -pk_s) v_cl = -pk_s;
    end
    if (v_cl > QUO_W'(27'sd8388607)) v_sat = 24'sh7fffff;
    else if (v_cl < -QUO_W'(27'sd8388608)) v_sat = 24'sh800000;
    else v_sat = v_cl[SAMP_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SETUP;
          cnt_d   = '0;
        end
      end
      ST_SETUP: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd6) begin
          cnt_d   = '0;
          state_d = (len_q == '0) ? ST_IDLE : ST_SAMP;
        end
      end
      ST_SAMP: begin
        cnt_d = cnt_q + 4'd1;
        if (div_start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          cnt_d   = '0;
          state_d = last_q ? ST_IDLE : ST_SAMP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      thr_q   <= THR_RESET;
      ov_q    <= OV_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_DIV && div_done) ovld_q <= 1'b1;
      else if (state_q == ST_OUT && !out_stall_i) ovld_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CLIP_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
          REG_PEAK_OVERSHOOT: ov_q  <= cfg_data_i[OV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      p0_q   <= (before_count_i != 2'd0) ? before_last_i : '0;
      p1_q   <= (after_count_i != 2'd0) ? after_first_i : '0;
      m0x2_q <= m0_in;
      m1x2_q <= m1_in;
      ssum_q <= 26'(ab_in) + 26'(aa_in);
      len_q  <= len_in;
      n_q    <= len_in + 7'd1;
      lin_q  <= (before_count_i < 2'd2) || (after_count_i < 2'd2);
      neg_q  <= polarity_i;
      addr_q <= start_address_i;
      k_q    <= 7'd1;
    end
    if (state_q == ST_SETUP) begin
      case (cnt_q)
        4'd1: n2_q  <= prod_q[12:0];
        4'd2: n3_q  <= prod_q[18:0];
        4'd3: cap_q <= prod_q[38:12];
        4'd4: peak_q <= (pk_min > 30'd8388607) ? 23'h7fffff : pk_min[PEAK_W-1:0];
        4'd5: m0n_q <= prod_q[34:0];
        4'd6: m1n_q <= prod_q[34:0];
        default: ;
      endcase
    end
    if (state_q == ST_SAMP) begin
      if (lin_q) begin
        if (cnt_q == 4'd1) acc_q <= prod_ext;
      end else begin
        case (cnt_q)
          4'd1: k2_q  <= prod_q[12:0];
          4'd2: k3_q  <= prod_q[18:0];
          4'd3: k2n_q <= prod_q[18:0];
          4'd4: kn2_q <= prod_q[18:0];
          4'd5: acc_q <= prod_ext <<< 1;
          4'd6: acc_q <= acc_q + prod_ext;
          4'd7: acc_q <= acc_q + (prod_ext <<< 1);
          default: ;
        endcase
      end
    end
    if (state_q == ST_DIV && div_done) begin
      samp_q <= v_sat;
      last_q <= (k_q == len_q);
    end
    if (state_q == ST_OUT && !out_stall_i) begin
      k_q    <= k_q + 7'd1;
      addr_q <= addr_q + 32'd1;
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = ovld_q;
  assign sample_o         = samp_q;
  assign sample_address_o = addr_q;
  assign peak_estimate_o  = peak_q;
  assign last_o           = last_q;

  a_valid_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_OUT)) else $error("result valid outside output step");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after transaction");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sample_o) && $stable(last_o)))
    else $error("stalled result changed");
  a_div_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV)) else $error("divide result outside wait");

endmodule

FILE: rtl/core/hcli_div.sv
// divide: quotient of a signed numerator by a positive divisor,
// floored, one quotient bit per cycle, saturated beyond 24 magnitude bits
module hcli_div import hcli_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic signed [QUO_W-1:0] quo_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [4:0]                      cnt_q, cnt_d;
  logic [ACC_W-1:0]                rem_q, rem_d;
  logic [DEN_W+QBITS-2:0]          dsh_q, dsh_d;
  logic [QBITS-1:0]                quo_q, quo_d;
  logic                            neg_q, neg_d;
  logic                            sat_q, sat_d;
  logic [ACC_W-1:0]                mag;
  logic [ACC_W-1:0]                udiv;
  logic [ACC_W-1:0]                dsh_ext;
  logic signed [QUO_W-1:0]         qext;

  assign mag  = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  // negative side takes the ceiling of the magnitude
  assign udiv = num_i[ACC_W-1] ? (mag + ACC_W'(den_i) - ACC_W'(1)) : mag;
  assign dsh_ext = ACC_W'(dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    sat_d  = sat_q;
    if (start_i) begin
      neg_d = num_i[ACC_W-1];
      quo_d = '0;
      if (udiv >= {{(ACC_W-DEN_W-QBITS){1'b0}}, den_i, {QBITS{1'b0}}}) begin
        sat_d  = 1'b1;
        done_d = 1'b1;
      end else begin
        sat_d  = 1'b0;
        busy_d = 1'b1;
        rem_d  = udiv;
        dsh_d  = {den_i, {(QBITS-1){1'b0}}};
        cnt_d  = 5'(QBITS);
      end
    end else if (busy_q) begin
      if (rem_q >= dsh_ext) begin
        rem_d = rem_q - dsh_ext;
        quo_d = {quo_q[QBITS-2:0], 1'b1};
      end else begin
        quo_d = {quo_q[QBITS-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    sat_q <= sat_d;
  end

  assign qext   = sat_q ? QUO_W'(27'sd16777216) : $signed({3'b000, quo_q});
  assign quo_o  = neg_q ? -qext : qext;
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divide done while busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divide started while busy");
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 5'd1) |=> (done_q && !busy_q)) else $error("divide did not finish");

endmodule

FILE: tb/tb_hermite_clip_interpolator.sv
`timescale 1ns / 100ps

module tb_hermite_clip_interpolator;
  import hcli_pkg::*;

  typedef struct {
    logic signed [SAMP_W-1:0] bfar, bmid, blast;
    logic [1:0]               bcount;
    logic signed [SAMP_W-1:0] afirst, asecond, athird;
    logic [1:0]               acount;
    logic [LEN_W-1:0]         len;
    logic [ADDR_W-1:0]        start;
    logic                     neg;
  } region_t;

  typedef struct {
    logic signed [SAMP_W-1:0] sample;
    logic [ADDR_W-1:0]        addr;
    logic [PEAK_W-1:0]        peak;
    logic                     last;
  } rebuilt_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [SAMP_W-1:0] before_far_i = '0, before_mid_i = '0, before_last_i = '0;
  logic [1:0]               before_count_i = '0;
  logic signed [SAMP_W-1:0] after_first_i = '0, after_second_i = '0, after_third_i = '0;
  logic [1:0]               after_count_i = '0;
  logic [LEN_W-1:0]         clip_length_i = '0;
  logic [ADDR_W-1:0]        start_address_i = '0;
  logic                     polarity_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [SAMP_W-1:0] sample_o;
  logic [ADDR_W-1:0]        sample_address_o;
  logic [PEAK_W-1:0]        peak_estimate_o;
  logic                     last_o;

  hermite_clip_interpolator dut (.*);

  // predictor copy of the registers
  logic [THR_W-1:0] thr_q = THR_RESET;
  logic [OV_W-1:0]  ov_q  = OV_RESET;

  rebuilt_t expected_samples[$];
  int unsigned mismatches = 0;
  int unsigned regions_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_hold = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d samples outstanding", expected_samples.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint floor_quot(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  task automatic predict_region(region_t r);
    longint bf, bm, bl, af, as2, at, len, n, n3, sb, sa, thr, raw, cap, pk;
    longint p0, p1, m0, m1, k, k2, k3, h00, h10, h01, h11, num, v;
    bit linear;
    rebuilt_t e;
    bf = r.bfar; bm = r.bmid; bl = r.blast;
    af = r.afirst; as2 = r.asecond; at = r.athird;
    len = r.len;
    if (len > MAX_CLIP_LEN) len = MAX_CLIP_LEN;
    n = len + 1;
    n3 = n * n * n;
    sb = (r.bcount >= 2) ? bl - bm : 0;
    sa = (r.acount >= 2) ? as2 - af : 0;
    thr = thr_q;
    raw = thr + (((mag(sb) + mag(sa)) * len) >>> 3);
    cap = (thr * longint'(ov_q)) >>> 12;
    pk = (raw < cap) ? raw : cap;
    if (pk > 8388607) pk = 8388607;
    linear = (r.bcount < 2) || (r.acount < 2);
    p0 = (r.bcount >= 1) ? bl : 0;
    p1 = (r.acount >= 1) ? af : 0;
    // tangents kept doubled
    m0 = (r.bcount == 3) ? bl - bf : 2 * (bl - bm);
    m1 = (r.acount == 3) ? at - af : 2 * (as2 - af);
    for (k = 1; k <= len; k++) begin
      if (linear) begin
        v = floor_quot(2 * (p0 * n + k * (p1 - p0)) + n, 2 * n);
      end else begin
        k2 = k * k;
        k3 = k2 * k;
        h00 = 2 * k3 - 3 * k2 * n + n3;
        h10 = k3 - 2 * k2 * n + k * n * n;
        h01 = -2 * k3 + 3 * k2 * n;
        h11 = k3 - k2 * n;
        num = 2 * h00 * p0 + h10 * m0 * n + 2 * h01 * p1 + h11 * m1 * n;
        v = floor_quot(2 * num + 2 * n3, 4 * n3);
        if (!r.neg && v > pk) v = pk;
        if (r.neg && v < -pk) v = -pk;
      end
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      e.sample = v[SAMP_W-1:0];
      e.addr = r.start + ADDR_W'(k - 1);
      e.peak = pk[PEAK_W-1:0];
      e.last = (k == len);
      expected_samples = {expected_samples, e};
    end
  endtask

  // call right after a rising edge; returns at the accepting edge
  task automatic send_region(region_t r);
    in_valid_i <= 1'b1;
    before_far_i <= r.bfar;
    before_mid_i <= r.bmid;
    before_last_i <= r.blast;
    before_count_i <= r.bcount;
    after_first_i <= r.afirst;
    after_second_i <= r.asecond;
    after_third_i <= r.athird;
    after_count_i <= r.acount;
    clip_length_i <= r.len;
    start_address_i <= r.start;
    polarity_i <= r.neg;
    do @(posedge clk_i); while (in_stall_o);
    predict_region(r);
    regions_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // zero-length regions leave no sample behind, so allow extra cycles
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_CLIP_THRESHOLD) thr_q = data[THR_W-1:0];
    else ov_q = data[OV_W-1:0];
  endtask

  task automatic set_regs(logic [THR_W-1:0] thr, logic [OV_W-1:0] ov);
    write_reg(REG_CLIP_THRESHOLD, thr);
    write_reg(REG_PEAK_OVERSHOOT, CFG_W'(ov));
  endtask

  function automatic logic signed [SAMP_W-1:0] rand_anchor(bit wide);
    int signed base;
    if (wide) return SAMP_W'($urandom);
    base = int'(thr_q) - 2000;
    return SAMP_W'(base + int'($urandom_range(4000)));
  endfunction

  function automatic region_t rand_region();
    region_t r;
    bit wide;
    int unsigned pick;
    wide = ($urandom_range(99) < 40);
    r.bfar = rand_anchor(wide);
    r.bmid = rand_anchor(wide);
    r.blast = rand_anchor(wide);
    r.afirst = rand_anchor(wide);
    r.asecond = rand_anchor(wide);
    r.athird = rand_anchor(wide);
    if (!wide && $urandom_range(1)) begin
      r.bfar = -r.bfar; r.bmid = -r.bmid; r.blast = -r.blast;
      r.afirst = -r.afirst; r.asecond = -r.asecond; r.athird = -r.athird;
    end
    if ($urandom_range(99) < 80) begin
      r.bcount = 2'($urandom_range(3, 2));
      r.acount = 2'($urandom_range(3, 2));
    end else begin
      r.bcount = 2'($urandom);
      r.acount = 2'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 84) r.len = LEN_W'($urandom_range(12, 1));
    else if (pick < 94) r.len = LEN_W'($urandom_range(64, 13));
    else if (pick < 98) r.len = LEN_W'($urandom_range(127, 65));
    else r.len = '0;
    r.start = ($urandom_range(9) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom;
    r.neg = 1'($urandom);
    return r;
  endfunction

  task automatic test_directed();
    region_t r;
    r = '{bfar: '0, bmid: '0, blast: '0, bcount: 2'd0, afirst: '0, asecond: '0,
          athird: '0, acount: 2'd0, len: 7'd4, start: 32'd0, neg: 1'b0};
    send_region(r);                                   // no anchors at all
    r.bcount = 2'd1; r.blast = 24'sh7FFFFF; r.acount = 2'd3;
    r.afirst = 24'sh800000; r.asecond = 24'sh7FFFFF; r.athird = 24'sh800000;
    send_region(r);                                   // line, one side short
    r.bcount = 2'd3; r.acount = 2'd1; r.len = 7'd1; r.start = 32'hFFFF_FFFF;
    send_region(r);
    r.bfar = 24'sh800000; r.bmid = 24'sh7FFFFF; r.blast = 24'sh800000;
    r.acount = 2'd3; r.len = 7'd5; r.start = 32'hFFFF_FFFE;
    send_region(r);                                   // hermite, full swing
    r.neg = 1'b1;
    send_region(r);
    r.bcount = 2'd2; r.acount = 2'd2; r.len = 7'd3;
    send_region(r);                                   // one-sided tangents
    r = '{bfar: 24'sh100000, bmid: 24'sh180000, blast: 24'sh0F0000, bcount: 2'd3,
          afirst: 24'sh0F8000, asecond: 24'sh1A0000, athird: 24'sh120000,
          acount: 2'd3, len: 7'd8, start: 32'h1234_5678, neg: 1'b0};
    send_region(r);                                   // overshoot gets clamped
    r.bmid = -r.bmid; r.blast = -r.blast; r.afirst = -r.afirst;
    r.asecond = -r.asecond; r.athird = -r.athird; r.bfar = -r.bfar; r.neg = 1'b1;
    send_region(r);
    r.len = 7'd0;
    send_region(r);                                   // zero length
    r.len = 7'd127;
    send_region(r);                                   // overlong, saturates
    r.len = MAX_CLIP_LEN; r.neg = 1'b0;
    send_region(r);
    r.bcount = 2'd3; r.acount = 2'd0; r.len = 7'd2;
    send_region(r);
    r.bcount = 2'd0; r.acount = 2'd2; r.len = 7'd2;
    send_region(r);
    drain();
  endtask

  task automatic test_random_regions(int unsigned count, bit hold_off);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (hold_off && i == count / 2) begin
        in_valid_i <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      if (burst == 0) begin
        pause_sender($urandom_range(20, 1));
        burst = $urandom_range(6, 1);
      end
      send_region(rand_region());
      burst--;
    end
    drain();
  endtask

  task automatic test_register_settings();
    set_regs(THR_RESET, OV_RESET);
    stall_pct = 0;
    test_random_regions(30, 1);
    set_regs('0, '0);
    stall_pct = 30;
    test_random_regions(25, 0);
    set_regs(23'h7FFFFF, 16'hFFFF);
    stall_pct = 50;
    test_random_regions(35, 1);
    set_regs(23'd1000, 16'd4096);
    stall_pct = 20;
    test_random_regions(30, 0);
    for (int unsigned p = 0; p < 3; p++) begin
      set_regs(THR_W'($urandom), OV_W'($urandom));
      stall_pct = $urandom_range(70);
      test_random_regions(25, p == 1);
    end
  endtask

  // receiver: stalls in runs of random length
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      stall_hold <= $urandom_range(6);
    end
  end

  always @(posedge clk_i) begin
    rebuilt_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample %0d at address %h", sample_o, sample_address_o);
      end else begin
        e = expected_samples.pop_front();
        samples_checked++;
        if (sample_o !== e.sample || sample_address_o !== e.addr ||
            peak_estimate_o !== e.peak || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: exp %0d @%h peak %0d last %b, got %0d @%h peak %0d last %b",
                     e.sample, e.addr, e.peak, e.last,
                     sample_o, sample_address_o, peak_estimate_o, last_o);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_settings();
    $display("%0d regions sent, %0d samples checked", regions_sent, samples_checked);
    $display("covered line and hermite paths, clamping, length edges and register extremes");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d samples missing", mismatches, expected_samples.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
